### rtl/quadrature_counter_with_speed_unit_macros.svh
// Assertion macros shared by the quadrature counter RTL.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef QUADRATURE_COUNTER_WITH_SPEED_UNIT_MACROS_SVH
`define QUADRATURE_COUNTER_WITH_SPEED_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define QCS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qcs check failed");
// Next-cycle implication.
`define QCS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qcs check failed");
`else
`define QCS_ASSERT_NOW(name, ante, cons)
`define QCS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### rtl/qcs_pkg.sv
// Shared types, constants and helpers for the quadrature counter with speed unit.
// No dependencies.
package qcs_pkg;

  localparam int DATA_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int PROD_W   = 64;

  localparam logic signed [DATA_W-1:0] STEP_UP   = 32'sd2;
  localparam logic signed [DATA_W-1:0] STEP_DOWN = -32'sd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20;

  typedef enum logic [1:0] {
    REG_REVERSE   = 2'd0,
    REG_PERIOD    = 2'd1,
    REG_RPM_SCALE = 2'd2,
    REG_RAD_SCALE = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  // Per-beat control carried down the pipe next to the payload.
  typedef struct packed {
    logic done;
    logic clr;
  } beat_ctl_t;

  // Clamp a signed 64-bit product to signed 32 bits.
  function automatic logic signed [DATA_W-1:0] sat_q16(input logic signed [PROD_W-1:0] p);
    logic over_pos;
    logic over_neg;
    over_pos = !p[PROD_W-1] && (p[PROD_W-2:DATA_W-1] != '0);
    over_neg = p[PROD_W-1] && (p[PROD_W-2:DATA_W-1] != '1);
    if (over_pos) begin
      sat_q16 = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (over_neg) begin
      sat_q16 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_q16 = p[DATA_W-1:0];
    end
  endfunction

endpackage

### rtl/qcs_scale.sv
// Speed scaling slice: signed count delta times unsigned Q16.16 factor, registered,
// then saturated to signed Q16.16. Depends on qcs_pkg.
module qcs_scale (
  input  logic                 clk,
  input  logic                 load,
  input  logic signed [31:0]   delta,
  input  logic        [31:0]   scale,
  output logic signed [31:0]   sat_value
);
  import qcs_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_full;

  // Zero-extend the factor so it multiplies as a positive value.
  assign prod_full = $signed({delta[DATA_W-1], delta}) * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_full;
    end
  end

  assign sat_value = sat_q16(prod_r);

endmodule

### rtl/quadrature_counter_with_speed_unit.sv
// Quadrature encoder counter (x2 on channel A) with periodic speed measurement.
// Depends on qcs_pkg, qcs_scale and quadrature_counter_with_speed_unit_macros.svh.
//
// Each input beat is one sample of encoder pins A and B plus a millisecond tick,
// or a clear command. Every edge of A moves the position by two counts, up when
// A equals B, down otherwise, inverted by reverse_direction; the count wraps at
// 32 bits. The first sample after reset, and a clear, take no count step but
// capture the level of A (a clear also zeroes the count and timer). After
// period_ms ticks (0 acts as 1, capped by the TIMER_WIDTH-bit timer) the count
// change over the period is latched and multiplied by rpm_scale and rad_scale,
// giving saturated signed Q16.16 rpm and rad/s. Every input beat yields exactly
// one output beat carrying position, the last period delta, both speeds, and
// tlast set when that beat closed a period. Throughput is one beat per clock
// while the output is not stalled; the accepting edge loads the input register,
// and the beat then passes the count stage, the multiplier register and the
// output register in turn before out_tvalid rises. Each stage advances on its
// own when the next one is free, so a stalled output only blocks the input once
// all four stages are full. Write configuration only while no beat is in flight.
`include "quadrature_counter_with_speed_unit_macros.svh"

module quadrature_counter_with_speed_unit #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,     // [0] pin_a, [1] pin_b, [2] ms_tick, [7:3] zero
  input  logic [0:0]   in_tuser,     // [0] command (0 sample, 1 clear)
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,    // [31:0] position, [63:32] period_delta,
                                     // [95:64] speed_rpm, [127:96] speed_rad
  output logic         out_tlast,    // period_done
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import qcs_pkg::*;

  localparam int TW_EXT = ((TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W) + 1;

  // ---------------------------------------------------------------- config regs
  logic                reverse_r;
  logic [PERIOD_W-1:0] period_r;
  logic [DATA_W-1:0]   rpm_scale_r;
  logic [DATA_W-1:0]   rad_scale_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r   <= 1'b0;
      period_r    <= PERIOD_RESET;
      rpm_scale_r <= '0;
      rad_scale_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_REVERSE:   reverse_r   <= cfg_pwdata[0];
        REG_PERIOD:    period_r    <= cfg_pwdata[PERIOD_W-1:0];
        REG_RPM_SCALE: rpm_scale_r <= cfg_pwdata;
        REG_RAD_SCALE: rad_scale_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_REVERSE:   cfg_prdata = {{(DATA_W-1){1'b0}}, reverse_r};
      REG_PERIOD:    cfg_prdata = {{(DATA_W-PERIOD_W){1'b0}}, period_r};
      REG_RPM_SCALE: cfg_prdata = rpm_scale_r;
      REG_RAD_SCALE: cfg_prdata = rad_scale_r;
      default:       cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipe control
  // Stage 0: input register. Stage 1: count result. Stage 2: products.
  // Stage 3: output register, which also holds the speed state.
  logic v0_r, v1_r, v2_r, out_valid_r;
  logic go0, go1, go2;
  logic take1, take2, take_out;

  assign take_out = !out_valid_r || out_tready;
  assign go2      = v2_r && take_out;
  assign take2    = !v2_r || go2;
  assign go1      = v1_r && take2;
  assign take1    = !v1_r || go1;
  assign go0      = v0_r && take1;
  assign in_tready = !v0_r || go0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready)  v0_r        <= in_tvalid;
      if (take1)      v1_r        <= go0;
      if (take2)      v2_r        <= go1;
      if (take_out)   out_valid_r <= go2;
    end
  end

  // ---------------------------------------------------------------- stage 0
  cmd_t s0_cmd_r;
  logic s0_a_r, s0_b_r, s0_tick_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s0_cmd_r  <= cmd_t'(in_tuser[0]);
      s0_a_r    <= in_tdata[0];
      s0_b_r    <= in_tdata[1];
      s0_tick_r <= in_tdata[2];
    end
  end

  // Counter state, advanced as each beat leaves stage 0.
  logic                     last_a_r, last_a_nxt;
  logic                     known_r, known_nxt;
  logic signed [DATA_W-1:0] count_r, count_nxt;
  logic signed [DATA_W-1:0] start_r, start_nxt;
  logic [TIMER_WIDTH-1:0]   ms_elapsed_r, ms_elapsed_nxt;
  logic signed [DATA_W-1:0] delta_r, delta_nxt;
  logic                     done_nxt;
  logic                     step_up;
  logic [TW_EXT-1:0]        ms_next_ext, tgt_ext, tmax_ext;

  always_comb begin
    last_a_nxt     = last_a_r;
    known_nxt      = known_r;
    count_nxt      = count_r;
    start_nxt      = start_r;
    ms_elapsed_nxt = ms_elapsed_r;
    delta_nxt      = delta_r;
    done_nxt       = 1'b0;
    step_up        = (s0_a_r == s0_b_r) ^ reverse_r;

    // Period target: zero acts as one, capped at the timer's maximum.
    tmax_ext    = TW_EXT'({TIMER_WIDTH{1'b1}});
    tgt_ext     = (period_r == '0) ? TW_EXT'(1) : TW_EXT'(period_r);
    if (tgt_ext > tmax_ext) begin
      tgt_ext = tmax_ext;
    end
    ms_next_ext = TW_EXT'(ms_elapsed_r) + TW_EXT'(1);

    if (s0_cmd_r == CMD_CLEAR) begin
      count_nxt      = '0;
      start_nxt      = '0;
      ms_elapsed_nxt = '0;
      delta_nxt      = '0;
      last_a_nxt     = s0_a_r;
      known_nxt      = 1'b1;
    end else begin
      if (!known_r) begin
        // first sample only learns the level of A
        last_a_nxt = s0_a_r;
        known_nxt  = 1'b1;
      end else if (s0_a_r != last_a_r) begin
        last_a_nxt = s0_a_r;
        count_nxt  = count_r + (step_up ? STEP_UP : STEP_DOWN);
      end
      if (s0_tick_r) begin
        if (ms_next_ext >= tgt_ext) begin
          delta_nxt      = count_nxt - start_r;
          start_nxt      = count_nxt;
          ms_elapsed_nxt = '0;
          done_nxt       = 1'b1;
        end else begin
          ms_elapsed_nxt = ms_next_ext[TIMER_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r     <= 1'b0;
      known_r      <= 1'b0;
      count_r      <= '0;
      start_r      <= '0;
      ms_elapsed_r <= '0;
      delta_r      <= '0;
    end else if (go0) begin
      last_a_r     <= last_a_nxt;
      known_r      <= known_nxt;
      count_r      <= count_nxt;
      start_r      <= start_nxt;
      ms_elapsed_r <= ms_elapsed_nxt;
      delta_r      <= delta_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [DATA_W-1:0] s1_count_r, s1_delta_r;
  beat_ctl_t                s1_ctl_r;

  always_ff @(posedge clk) begin
    if (go0) begin
      s1_count_r    <= count_nxt;
      s1_delta_r    <= delta_nxt;
      s1_ctl_r.done <= done_nxt;
      s1_ctl_r.clr  <= (s0_cmd_r == CMD_CLEAR);
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [DATA_W-1:0] s2_count_r, s2_delta_r;
  beat_ctl_t                s2_ctl_r;
  logic signed [DATA_W-1:0] rpm_sat, rad_sat;

  always_ff @(posedge clk) begin
    if (go1) begin
      s2_count_r <= s1_count_r;
      s2_delta_r <= s1_delta_r;
      s2_ctl_r   <= s1_ctl_r;
    end
  end

  qcs_scale u_rpm (
    .clk       (clk),
    .load      (go1),
    .delta     (s1_delta_r),
    .scale     (rpm_scale_r),
    .sat_value (rpm_sat)
  );

  qcs_scale u_rad (
    .clk       (clk),
    .load      (go1),
    .delta     (s1_delta_r),
    .scale     (rad_scale_r),
    .sat_value (rad_sat)
  );

  // ---------------------------------------------------------------- output stage
  // The speed fields double as the speed state: hold them unless a period
  // closes or a clear passes.
  logic signed [DATA_W-1:0] out_pos_r, out_delta_r;
  logic signed [DATA_W-1:0] rpm_value_r, rad_value_r;
  logic                     out_done_r;

  always_ff @(posedge clk) begin
    if (go2) begin
      out_pos_r   <= s2_count_r;
      out_delta_r <= s2_delta_r;
      out_done_r  <= s2_ctl_r.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_value_r <= '0;
      rad_value_r <= '0;
    end else if (go2) begin
      if (s2_ctl_r.clr) begin
        rpm_value_r <= '0;
        rad_value_r <= '0;
      end else if (s2_ctl_r.done) begin
        rpm_value_r <= rpm_sat;
        rad_value_r <= rad_sat;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {rad_value_r, rpm_value_r, out_delta_r, out_pos_r};
  assign out_tlast  = out_done_r;

  // ---------------------------------------------------------------- checks
  `QCS_ASSERT_NEXT(a_clear_zeroes_count, go0 && (s0_cmd_r == CMD_CLEAR),
    (count_r == '0) && (start_r == '0) && (ms_elapsed_r == '0) && known_r)
  `QCS_ASSERT_NEXT(a_done_needs_tick, go0 && !s0_tick_r, !s1_ctl_r.done)
  `QCS_ASSERT_NEXT(a_clear_zeroes_speed, go2 && s2_ctl_r.clr,
    (rpm_value_r == '0) && (rad_value_r == '0))
  `QCS_ASSERT_NOW(a_full_pipe_blocks, v0_r && v1_r && v2_r && out_valid_r && !out_tready,
    !in_tready)

endmodule
